[rtl/core/mpc_pkg.sv]
// Package for the multichannel piece counter core.
// Holds register indexes, mode and phase codes, reason bits and the channel record.
`timescale 1ns / 1ps

package mpc_pkg;

  localparam int unsigned CHANNELS_DEF    = 8;
  localparam int unsigned COUNTER_MAX_DEF = 65535;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  // Reject reason bits
  localparam logic [4:0] R_LONG  = 5'h01;
  localparam logic [4:0] R_CLOSE = 5'h02;
  localparam logic [4:0] R_FAST  = 5'h04;
  localparam logic [4:0] R_MANY  = 5'h08;
  localparam logic [4:0] R_START = 5'h10;

  // Handshake phases
  localparam logic [1:0] PH_COUNT    = 2'd0;
  localparam logic [1:0] PH_ACK_LOW  = 2'd1;
  localparam logic [1:0] PH_ACK_HIGH = 2'd2;

  // Run modes
  localparam logic [1:0] RUN_GO        = 2'd1;
  localparam logic [1:0] RUN_PHASE_RST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BATCH_TARGET  = 3'd0,
    CFG_PRE_STOP      = 3'd1,
    CFG_MIN_LEN       = 3'd2,
    CFG_MAX_LEN       = 3'd3,
    CFG_MIN_GAP       = 3'd4,
    CFG_MIN_DOOR      = 3'd5,
    CFG_DOOR_DELAY    = 3'd6,
    CFG_START_REJECTS = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CM_NORMAL   = 2'd0,
    CM_SEPARATE = 2'd1,
    CM_PRE      = 2'd2
  } chmode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GLOB,
    ST_CHAN,
    ST_FIN
  } state_e;

  // Per-channel record kept in the state memory
  typedef struct packed {
    logic [15:0] gap;
    logic [15:0] piece;
    logic [15:0] countdown;
    logic [15:0] open_ticks;
  } chan_rec_t;

endpackage

[rtl/core/mpc_if.sv]
// Stream interfaces for the piece counter: poll tick words in, result words out.
// Depends on nothing.
`timescale 1ns / 1ps

interface mpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sensor_bits;
  logic       filler_ack;
  logic [1:0] run_mode;

  modport source (output valid, sensor_bits, filler_ack, run_mode, input ready);
  modport sink (input valid, sensor_bits, filler_ack, run_mode, output ready);
endinterface

interface mpc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  door_close_mask;
  logic        vibrator_on;
  logic        reject_out;
  logic        complete_out;
  logic [4:0]  reject_reasons;
  logic [4:0]  last_reject_reasons;
  logic [15:0] batch_count;
  logic [15:0] next_count;
  logic        overcount_error;
  logic        len_sat_error;
  logic [15:0] batch_time;
  logic [1:0]  handshake_phase;

  modport source (output valid, door_close_mask, vibrator_on, reject_out, complete_out,
                  reject_reasons, last_reject_reasons, batch_count, next_count,
                  overcount_error, len_sat_error, batch_time, handshake_phase,
                  input ready);
  modport sink (input valid, door_close_mask, vibrator_on, reject_out, complete_out,
                reject_reasons, last_reject_reasons, batch_count, next_count,
                overcount_error, len_sat_error, batch_time, handshake_phase,
                output ready);
endinterface

[rtl/core/multichannel_piece_counter_core.sv]
// Multichannel piece counter core: one poll tick word in, one status word out.
// Ticks are taken one at a time: the next one is accepted only after the result
// word is loaded. The channel walk goes over the state memory one channel record
// per cycle; a result word still waiting in the output register holds the next
// tick back.
// Reset: all counters, flags and doors cleared, configuration at its defaults.
`timescale 1ns / 1ps

module multichannel_piece_counter_core
  import mpc_pkg::*;
#(
  parameter int unsigned CHANNELS    = CHANNELS_DEF,
  parameter int unsigned COUNTER_MAX = COUNTER_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mpc_in_if.sink                in_i,
  mpc_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CW-1:0] LastCh  = CW'(CHANNELS - 1);
  localparam logic [15:0]   CntMax  = 16'(COUNTER_MAX);

  // Configuration registers
  logic [15:0] batch_target_q, pre_stop_q, min_len_q, max_len_q;
  logic [15:0] min_gap_q, min_door_q, door_delay_q;
  logic [7:0]  start_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_target_q <= 16'd100;
      pre_stop_q     <= 16'd100;
      min_len_q      <= 16'd1;
      max_len_q      <= 16'hFFFF;
      min_gap_q      <= '0;
      min_door_q     <= '0;
      door_delay_q   <= '0;
      start_lim_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BATCH_TARGET:  batch_target_q <= cfg_data_i;
        CFG_PRE_STOP:      pre_stop_q     <= cfg_data_i;
        CFG_MIN_LEN:       min_len_q      <= cfg_data_i;
        CFG_MAX_LEN:       max_len_q      <= cfg_data_i;
        CFG_MIN_GAP:       min_gap_q      <= cfg_data_i;
        CFG_MIN_DOOR:      min_door_q     <= cfg_data_i;
        CFG_DOOR_DELAY:    door_delay_q   <= cfg_data_i;
        CFG_START_REJECTS: start_lim_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Control and global state
  state_e state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [7:0]  sens_q;
  logic        ack_q;
  logic [1:0]  rmode_q;
  logic        ho_q, ho_d;
  logic [4:0]  smp_q, smp_d;

  chmode_e         mode_q [CHANNELS];
  chmode_e         mode_d [CHANNELS];
  logic [CHANNELS-1:0] closed_q, closed_d, prev_q, prev_d;

  logic [15:0] nt_q, nt_d, pt_q, pt_d, run_q, run_d, btime_q, btime_d;
  logic [4:0]  nr_q, nr_d, pr_q, pr_d, lat_q, lat_d;
  logic [7:0]  srd_q, srd_d;
  logic [1:0]  ph_q, ph_d;
  logic        vib_q, vib_d, rej_q, rej_d, cmp_q, cmp_d, over_q, over_d, det_q, det_d;

  logic        out_vld_q, out_load;
  logic [7:0]  mask;

  // Memory port signals
  logic          mem_we, mem_re;
  logic [CW-1:0] mem_raddr;
  chan_rec_t     mem_rd, mem_wd;

  logic in_fire;
  assign in_fire = in_i.valid && in_i.ready;

  mpc_chan_mem #(
    .DEPTH(CHANNELS),
    .AW   (CW)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(idx_q),
    .wdata_i(mem_wd),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rd)
  );

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake
  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) state_d = ST_GLOB;
      end
      ST_GLOB: state_d = ST_CHAN;
      ST_CHAN: begin
        if (idx_q == LastCh) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Tick datapath: global step, then one channel record per cycle
  always_comb begin
    chan_rec_t   rec;
    logic        now, was, closed0;
    logic [7:0]  sh;
    logic [15:0] cdl;
    logic [16:0] dsum;

    idx_d    = idx_q;
    ho_d     = ho_q;
    smp_d    = smp_q;
    mode_d   = mode_q;
    closed_d = closed_q;
    prev_d   = prev_q;
    nt_d = nt_q; pt_d = pt_q; run_d = run_q; btime_d = btime_q;
    nr_d = nr_q; pr_d = pr_q; lat_d = lat_q; srd_d = srd_q; ph_d = ph_q;
    vib_d = vib_q; rej_d = rej_q; cmp_d = cmp_q; over_d = over_q; det_d = det_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    rec       = mem_rd;
    mem_wd    = mem_rd;
    now = 1'b0; was = 1'b0; closed0 = 1'b0; sh = '0; cdl = '0; dsum = '0;

    case (state_q)
      ST_GLOB: begin
        // Run time, vibrator and reject sampling
        if (rmode_q == RUN_GO) begin
          if (run_d != SAT16) run_d = run_d + 16'd1;
        end else begin
          vib_d = 1'b0;
        end
        if ((pt_q >= pre_stop_q || pt_q >= batch_target_q) && pt_q != '0) vib_d = 1'b0;
        smp_d = nr_q;
        if (nr_q != '0) begin
          lat_d = nr_q;
          rej_d = 1'b1;
        end
        // Filler handshake
        ho_d = 1'b0;
        if (rmode_q == RUN_PHASE_RST) ph_d = PH_COUNT;
        case (ph_d)
          PH_COUNT: begin
            if (nt_q >= batch_target_q) begin
              if (srd_q < start_lim_q) begin
                srd_d = srd_q + 8'd1;
                nr_d  = nr_d | R_START;
              end
              btime_d = run_d;
              cmp_d   = 1'b1;
              ph_d    = PH_ACK_LOW;
            end
          end
          PH_ACK_LOW: begin
            if (!ack_q) begin
              ph_d  = PH_ACK_HIGH;
              cmp_d = 1'b0;
              rej_d = 1'b0;
            end
          end
          PH_ACK_HIGH: begin
            if (ack_q) begin
              for (int i = 0; i < CHANNELS; i++) begin
                mode_d[i] = (pt_q < batch_target_q) ? CM_NORMAL : CM_SEPARATE;
              end
              nt_d  = pt_q;
              pt_d  = '0;
              nr_d  = pr_q;
              pr_d  = '0;
              run_d = '0;
              cmp_d = 1'b0;
              rej_d = 1'b0;
              vib_d = 1'b1;
              ho_d  = 1'b1;
              ph_d  = PH_COUNT;
            end
          end
          default: ;
        endcase
        // Fetch channel zero
        mem_re    = 1'b1;
        mem_raddr = '0;
        idx_d     = '0;
      end

      ST_CHAN: begin
        closed0 = closed_q[idx_q];
        // Door open time and handover reopen
        if (!closed0 && rec.open_ticks < CntMax) rec.open_ticks = rec.open_ticks + 16'd1;
        if (ho_q) begin
          rec.countdown = '0;
          if (closed0) begin
            closed_d[idx_q] = 1'b0;
            rec.open_ticks  = '0;
          end
        end
        // Edge detection
        sh  = sens_q >> idx_q;
        now = (32'(idx_q) < 32'd8) && sh[0];
        was = prev_q[idx_q];
        if (!now && !was) begin
          if (rec.gap < CntMax) rec.gap = rec.gap + 16'd1;
        end else if (now && !was) begin
          rec.piece = '0;
        end else if (now && was) begin
          if (rec.piece < CntMax) rec.piece = rec.piece + 16'd1;
          else det_d = 1'b1;
        end else begin
          if (rec.piece >= min_len_q) begin
            case (mode_q[idx_q])
              CM_NORMAL: begin
                if (nt_d >= batch_target_q) over_d = 1'b1;
                if (rec.piece > max_len_q) nr_d = nr_d | R_LONG;
                if (nt_d != SAT16) nt_d = nt_d + 16'd1;
                if (nt_d == batch_target_q) begin
                  for (int i = 0; i < CHANNELS; i++) mode_d[i] = CM_SEPARATE;
                end
              end
              CM_SEPARATE: begin
                cdl = (door_delay_q != '0) ? door_delay_q : 16'd1;
                if (rec.piece > max_len_q) pr_d = pr_d | R_LONG;
                if (rec.gap < min_gap_q) begin
                  nr_d = nr_d | R_CLOSE;
                  pr_d = pr_d | R_CLOSE;
                end
                dsum = {1'b0, rec.open_ticks} + {1'b0, cdl};
                if (dsum < {1'b0, min_door_q}) begin
                  cdl  = min_door_q - dsum[15:0];
                  nr_d = nr_d | R_FAST;
                  pr_d = pr_d | R_FAST;
                end
                rec.countdown = cdl;
                if (pt_d != SAT16) pt_d = pt_d + 16'd1;
                mode_d[idx_q] = CM_PRE;
              end
              CM_PRE: begin
                if (rec.piece > max_len_q) pr_d = pr_d | R_LONG;
                if (pt_d != SAT16) pt_d = pt_d + 16'd1;
              end
              default: ;
            endcase
          end
          rec.gap = '0;
          if (pt_d > batch_target_q) pr_d = pr_d | R_MANY;
        end
        prev_d[idx_q] = now;
        // Door countdown
        if (rec.countdown != '0) begin
          rec.countdown = rec.countdown - 16'd1;
          if (rec.countdown == '0) closed_d[idx_q] = 1'b1;
        end
        // Write back and fetch the next channel
        mem_we = 1'b1;
        mem_wd = rec;
        if (idx_q != LastCh) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + CW'(1);
          idx_d     = idx_q + CW'(1);
        end
      end

      default: ;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; ho_q <= 1'b0; smp_q <= '0;
      for (int i = 0; i < CHANNELS; i++) mode_q[i] <= CM_NORMAL;
      closed_q <= '0; prev_q <= '0;
      nt_q <= '0; pt_q <= '0; run_q <= '0; btime_q <= '0;
      nr_q <= '0; pr_q <= '0; lat_q <= '0; srd_q <= '0; ph_q <= PH_COUNT;
      vib_q <= 1'b0; rej_q <= 1'b0; cmp_q <= 1'b0; over_q <= 1'b0; det_q <= 1'b0;
    end else begin
      idx_q <= idx_d; ho_q <= ho_d; smp_q <= smp_d;
      mode_q <= mode_d; closed_q <= closed_d; prev_q <= prev_d;
      nt_q <= nt_d; pt_q <= pt_d; run_q <= run_d; btime_q <= btime_d;
      nr_q <= nr_d; pr_q <= pr_d; lat_q <= lat_d; srd_q <= srd_d; ph_q <= ph_d;
      vib_q <= vib_d; rej_q <= rej_d; cmp_q <= cmp_d; over_q <= over_d; det_q <= det_d;
    end
  end

  // Hold the accepted tick word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sens_q  <= in_i.sensor_bits;
      ack_q   <= in_i.filler_ack;
      rmode_q <= in_i.run_mode;
    end
  end

  // Door mask over the first eight channels
  always_comb begin
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < CHANNELS) mask[i] = closed_q[i % CHANNELS];
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.door_close_mask     <= mask;
      out_o.vibrator_on         <= vib_q;
      out_o.reject_out          <= rej_q;
      out_o.complete_out        <= cmp_q;
      out_o.reject_reasons      <= smp_q;
      out_o.last_reject_reasons <= lat_q;
      out_o.batch_count         <= nt_q;
      out_o.next_count          <= pt_q;
      out_o.overcount_error     <= over_q;
      out_o.len_sat_error       <= det_q;
      out_o.batch_time          <= btime_q;
      out_o.handshake_phase     <= ph_q;
    end
  end

  assign out_o.valid = out_vld_q;

  // Sticky error flags never drop
  assert property (@(posedge clk_i) disable iff (!rst_ni) over_q |=> over_q)
    else $error("overcount flag dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni) det_q |=> det_q)
    else $error("detect flag dropped");
  // An accepted word starts the global step
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> state_q == ST_GLOB)
    else $error("accepted word not processed");

endmodule

[rtl/core/mpc_chan_mem.sv]
// Per-channel state memory: one record per channel, one write and one read port.
// Valid bits make never-written entries read as zero. Uses mpc_pkg.
`timescale 1ns / 1ps

module mpc_chan_mem
  import mpc_pkg::*;
#(
  parameter int unsigned DEPTH = CHANNELS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  chan_rec_t     wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output chan_rec_t     rdata_o
);

  chan_rec_t        mem [DEPTH];
  chan_rec_t        rdata_q;
  logic [DEPTH-1:0] vld_q;
  logic             rvld_q;

  // Write and registered read of the array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Track written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

[tb/sv/tb_multichannel_piece_counter_core.sv]
// Testbench for the multichannel piece counter core: poll tick words in, status words out.
// Depends on mpc_pkg, the mpc_in_if / mpc_out_if interfaces and the core itself.
`timescale 1ns / 1ps

module tb_multichannel_piece_counter_core;
  import mpc_pkg::*;

  localparam int unsigned NCH       = CHANNELS_DEF;
  localparam int unsigned CNT_MAX   = COUNTER_MAX_DEF;
  localparam int unsigned LATENCY   = NCH + 3;
  localparam logic [1:0]  RUN_STOP  = 2'd0;
  localparam logic [1:0]  RUN_UNDEF = 2'd3;
  localparam int unsigned HOLD_TICKS = 40;

  typedef struct packed {
    logic [7:0] sensor_bits;
    logic       filler_ack;
    logic [1:0] run_mode;
  } tick_t;

  typedef struct packed {
    logic [7:0]  door_close_mask;
    logic        vibrator_on;
    logic        reject_out;
    logic        complete_out;
    logic [4:0]  reject_reasons;
    logic [4:0]  last_reject_reasons;
    logic [15:0] batch_count;
    logic [15:0] next_count;
    logic        overcount_error;
    logic        len_sat_error;
    logic [15:0] batch_time;
    logic [1:0]  handshake_phase;
  } status_t;

  typedef struct packed {
    logic [7:0] sensor_bits;
    logic       filler_ack;
    logic [1:0] run_mode;
    logic       typed;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mpc_in_if  in_if ();
  mpc_out_if out_if ();

  multichannel_piece_counter_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock: 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Predictor copy of the configuration
  int unsigned cfg_target, cfg_pre_stop, cfg_min_len, cfg_max_len;
  int unsigned cfg_min_gap, cfg_min_door, cfg_delay, cfg_start_limit;

  // Predictor copy of the block state
  logic [7:0]  prev_pres;
  int unsigned gap_cnt [NCH];
  int unsigned len_cnt [NCH];
  chmode_e     ch_mode [NCH];
  int unsigned close_cnt [NCH];
  logic [7:0]  door_shut;
  int unsigned open_cnt [NCH];
  int unsigned bottle_total, next_total, run_cnt, last_batch_time, start_rej_cnt;
  logic [4:0]  bottle_reasons, next_reasons, latched;
  logic [1:0]  hs_phase;
  logic        vib, rej, done_flag, over_flag, det_flag;

  status_t expected_status [$];
  int unsigned mismatches;
  int unsigned ticks_sent;
  int unsigned words_seen;

  // Idling controls
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  logic        hold_active;

  function automatic void reset_model();
    cfg_target = 100; cfg_pre_stop = 100; cfg_min_len = 1; cfg_max_len = 65535;
    cfg_min_gap = 0; cfg_min_door = 0; cfg_delay = 0; cfg_start_limit = 0;
    prev_pres = '0;
    door_shut = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      gap_cnt[ch] = 0; len_cnt[ch] = 0; ch_mode[ch] = CM_NORMAL;
      close_cnt[ch] = 0; open_cnt[ch] = 0;
    end
    bottle_total = 0; next_total = 0; run_cnt = 0; last_batch_time = 0;
    start_rej_cnt = 0;
    bottle_reasons = '0; next_reasons = '0; latched = '0;
    hs_phase = PH_COUNT;
    vib = 0; rej = 0; done_flag = 0; over_flag = 0; det_flag = 0;
  endfunction

  // Work out the status word caused by one poll tick and advance the state
  function automatic status_t count_tick(tick_t t);
    status_t s;
    logic [4:0] reas;
    int unsigned cd;
    logic now_p, was_p;
    // run time, vibrator and door open time bookkeeping
    if (t.run_mode == RUN_GO) begin
      if (run_cnt < 65535) run_cnt++;
    end else begin
      vib = 0;
    end
    if ((next_total >= cfg_pre_stop || next_total >= cfg_target) && next_total > 0) vib = 0;
    for (int ch = 0; ch < NCH; ch++)
      if (open_cnt[ch] < CNT_MAX && !door_shut[ch]) open_cnt[ch]++;
    reas = bottle_reasons;
    if (reas != 0) begin
      latched = reas;
      rej = 1;
    end
    // filler handshake
    if (t.run_mode == RUN_PHASE_RST) hs_phase = PH_COUNT;
    case (hs_phase)
      PH_COUNT: begin
        if (bottle_total >= cfg_target) begin
          if (start_rej_cnt < cfg_start_limit) begin
            start_rej_cnt++;
            bottle_reasons |= R_START;
          end
          last_batch_time = run_cnt;
          done_flag = 1;
          hs_phase = PH_ACK_LOW;
        end
      end
      PH_ACK_LOW: begin
        if (!t.filler_ack) begin
          hs_phase = PH_ACK_HIGH;
          done_flag = 0;
          rej = 0;
        end
      end
      PH_ACK_HIGH: begin
        if (t.filler_ack) begin
          // hand the pre count over and reopen the doors
          for (int ch = 0; ch < NCH; ch++) begin
            ch_mode[ch] = (next_total < cfg_target) ? CM_NORMAL : CM_SEPARATE;
            close_cnt[ch] = 0;
            if (door_shut[ch]) begin
              door_shut[ch] = 0;
              open_cnt[ch] = 0;
            end
          end
          bottle_total = next_total; next_total = 0;
          bottle_reasons = next_reasons; next_reasons = '0;
          run_cnt = 0; done_flag = 0; rej = 0; vib = 1;
          hs_phase = PH_COUNT;
        end
      end
      default: ;
    endcase
    // channel walk, lowest channel first
    for (int ch = 0; ch < NCH; ch++) begin
      now_p = (ch < 8) ? t.sensor_bits[ch] : 1'b0;
      was_p = prev_pres[ch];
      if (!now_p && !was_p) begin
        if (gap_cnt[ch] < CNT_MAX) gap_cnt[ch]++;
      end else if (now_p && !was_p) begin
        len_cnt[ch] = 0;
      end else if (now_p && was_p) begin
        if (len_cnt[ch] < CNT_MAX) len_cnt[ch]++;
        else det_flag = 1;
      end else begin
        if (len_cnt[ch] >= cfg_min_len) begin
          case (ch_mode[ch])
            CM_NORMAL: begin
              if (bottle_total >= cfg_target) over_flag = 1;
              if (len_cnt[ch] > cfg_max_len) bottle_reasons |= R_LONG;
              if (bottle_total < 65535) bottle_total++;
              if (bottle_total == cfg_target)
                for (int k = 0; k < NCH; k++) ch_mode[k] = CM_SEPARATE;
            end
            CM_SEPARATE: begin
              cd = (cfg_delay > 0) ? cfg_delay : 1;
              if (len_cnt[ch] > cfg_max_len) next_reasons |= R_LONG;
              if (gap_cnt[ch] < cfg_min_gap) begin
                bottle_reasons |= R_CLOSE;
                next_reasons |= R_CLOSE;
              end
              if (open_cnt[ch] + cd < cfg_min_door) begin
                cd = cfg_min_door - (open_cnt[ch] + cd);
                bottle_reasons |= R_FAST;
                next_reasons |= R_FAST;
              end
              close_cnt[ch] = cd;
              if (next_total < 65535) next_total++;
              ch_mode[ch] = CM_PRE;
            end
            CM_PRE: begin
              if (len_cnt[ch] > cfg_max_len) next_reasons |= R_LONG;
              if (next_total < 65535) next_total++;
            end
            default: ;
          endcase
        end
        gap_cnt[ch] = 0;
        if (next_total > cfg_target) next_reasons |= R_MANY;
      end
      prev_pres[ch] = now_p;
    end
    // door countdowns
    for (int ch = 0; ch < NCH; ch++) begin
      if (close_cnt[ch] > 0) begin
        close_cnt[ch]--;
        if (close_cnt[ch] == 0) door_shut[ch] = 1;
      end
    end
    s.door_close_mask     = door_shut;
    s.vibrator_on         = vib;
    s.reject_out          = rej;
    s.complete_out        = done_flag;
    s.reject_reasons      = reas;
    s.last_reject_reasons = latched;
    s.batch_count         = bottle_total[15:0];
    s.next_count          = next_total[15:0];
    s.overcount_error     = over_flag;
    s.len_sat_error       = det_flag;
    s.batch_time          = last_batch_time[15:0];
    s.handshake_phase     = hs_phase;
    return s;
  endfunction

  task automatic report(string field, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= 30)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_BATCH_TARGET:  cfg_target = value;
      CFG_PRE_STOP:      cfg_pre_stop = value;
      CFG_MIN_LEN:       cfg_min_len = value;
      CFG_MAX_LEN:       cfg_max_len = value;
      CFG_MIN_GAP:       cfg_min_gap = value;
      CFG_MIN_DOOR:      cfg_min_door = value;
      CFG_DOOR_DELAY:    cfg_delay = value;
      CFG_START_REJECTS: cfg_start_limit = value[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2,
                           logic [15:0] v3, logic [15:0] v4, logic [15:0] v5,
                           logic [15:0] v6, logic [7:0] v7);
    write_reg(CFG_BATCH_TARGET, v0);
    write_reg(CFG_PRE_STOP, v1);
    write_reg(CFG_MIN_LEN, v2);
    write_reg(CFG_MAX_LEN, v3);
    write_reg(CFG_MIN_GAP, v4);
    write_reg(CFG_MIN_DOOR, v5);
    write_reg(CFG_DOOR_DELAY, v6);
    write_reg(CFG_START_REJECTS, {8'h00, v7});
  endtask

  // Offer one tick word, hold it until accepted, then predict its status word
  task automatic send_tick(tick_t t, logic typed);
    status_t s;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
    @(negedge clk_i);
    in_if.valid       = 1'b1;
    in_if.sensor_bits = t.sensor_bits;
    in_if.filler_ack  = t.filler_ack;
    in_if.run_mode    = t.run_mode;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    s = count_tick(t);
    // right after reset the word reads as all zero
    if (typed) s = '0;
    expected_status.push_back(s);
    ticks_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Well-formed tick streams: pieces persist over ticks, filler answers the handshake
  task automatic random_ticks(int unsigned n);
    tick_t t;
    logic [7:0] level;
    int unsigned r;
    level = '0;
    for (int i = 0; i < n; i++) begin
      for (int ch = 0; ch < 8; ch++)
        if ($urandom_range(99) < 30) level[ch] = ~level[ch];
      r = $urandom_range(99);
      t.sensor_bits = (r < 10) ? 8'($urandom) : level;
      case (hs_phase)
        PH_ACK_LOW:  t.filler_ack = ($urandom_range(99) < 30);
        PH_ACK_HIGH: t.filler_ack = ($urandom_range(99) < 70);
        default:     t.filler_ack = ($urandom_range(99) < 80);
      endcase
      r = $urandom_range(99);
      if (r < 85)      t.run_mode = RUN_GO;
      else if (r < 90) t.run_mode = RUN_STOP;
      else if (r < 95) t.run_mode = RUN_PHASE_RST;
      else             t.run_mode = RUN_UNDEF;
      send_tick(t, 1'b0);
    end
  endtask

  // Walk the idle patterns over one configuration
  task automatic random_phase(int unsigned per_chunk, logic with_hold);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if (with_hold && p == 0) hold_req = 1'b1;
      random_ticks(per_chunk);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready = 1'b0;
    else out_if.ready = !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    hold_active = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_active = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_active = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  // Check each status word against the oldest expectation
  always @(posedge clk_i) begin
    status_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.door_close_mask, out_if.vibrator_on, out_if.reject_out,
              out_if.complete_out, out_if.reject_reasons, out_if.last_reject_reasons,
              out_if.batch_count, out_if.next_count, out_if.overcount_error,
              out_if.len_sat_error, out_if.batch_time, out_if.handshake_phase};
      words_seen++;
      if (expected_status.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        want = expected_status.pop_front();
        if (got.door_close_mask != want.door_close_mask)
          report("door_close_mask", got.door_close_mask, want.door_close_mask);
        if (got.vibrator_on != want.vibrator_on)
          report("vibrator_on", got.vibrator_on, want.vibrator_on);
        if (got.reject_out != want.reject_out)
          report("reject_out", got.reject_out, want.reject_out);
        if (got.complete_out != want.complete_out)
          report("complete_out", got.complete_out, want.complete_out);
        if (got.reject_reasons != want.reject_reasons)
          report("reject_reasons", got.reject_reasons, want.reject_reasons);
        if (got.last_reject_reasons != want.last_reject_reasons)
          report("last_reject_reasons", got.last_reject_reasons, want.last_reject_reasons);
        if (got.batch_count != want.batch_count)
          report("batch_count", got.batch_count, want.batch_count);
        if (got.next_count != want.next_count)
          report("next_count", got.next_count, want.next_count);
        if (got.overcount_error != want.overcount_error)
          report("overcount_error", got.overcount_error, want.overcount_error);
        if (got.len_sat_error != want.len_sat_error)
          report("len_sat_error", got.len_sat_error, want.len_sat_error);
        if (got.batch_time != want.batch_time)
          report("batch_time", got.batch_time, want.batch_time);
        if (got.handshake_phase != want.handshake_phase)
          report("handshake_phase", got.handshake_phase, want.handshake_phase);
      end
    end
  end

  // Overall time limit
  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence
  initial begin
    dir_row_t rows [] = '{
      '{8'h00, 1'b1, RUN_STOP,      1'b1},
      '{8'hFF, 1'b1, RUN_GO,        1'b0},
      '{8'hFF, 1'b1, RUN_GO,        1'b0},
      '{8'h00, 1'b1, RUN_GO,        1'b0},
      '{8'h00, 1'b1, RUN_GO,        1'b0},
      '{8'h00, 1'b0, RUN_GO,        1'b0},
      '{8'h00, 1'b1, RUN_GO,        1'b0},
      '{8'h01, 1'b1, RUN_GO,        1'b0},
      '{8'h01, 1'b1, RUN_GO,        1'b0},
      '{8'h01, 1'b1, RUN_GO,        1'b0},
      '{8'h01, 1'b1, RUN_GO,        1'b0},
      '{8'h00, 1'b1, RUN_GO,        1'b0},
      '{8'h80, 1'b0, RUN_UNDEF,     1'b0},
      '{8'h00, 1'b0, RUN_UNDEF,     1'b0},
      '{8'h80, 1'b1, RUN_PHASE_RST, 1'b0},
      '{8'h00, 1'b1, RUN_GO,        1'b0},
      '{8'h55, 1'b0, RUN_GO,        1'b0},
      '{8'hAA, 1'b1, RUN_GO,        1'b0},
      '{8'h00, 1'b0, RUN_STOP,      1'b0},
      '{8'h00, 1'b1, RUN_GO,        1'b0},
      '{8'h00, 1'b1, RUN_GO,        1'b0},
      '{8'h00, 1'b1, RUN_GO,        1'b0}
    };
    tick_t t;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BATCH_TARGET;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.sensor_bits = '0;
    in_if.filler_ack = 1'b0;
    in_if.run_mode = RUN_STOP;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    ticks_sent = 0;
    words_seen = 0;
    reset_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: tiny bottle, tight limits, one start reject
    write_all(16'd2, 16'd1, 16'd1, 16'd2, 16'd3, 16'd5, 16'd0, 8'd1);
    foreach (rows[i]) begin
      t = '{rows[i].sensor_bits, rows[i].filler_ack, rows[i].run_mode};
      send_tick(t, rows[i].typed);
    end
    drain();

    // Small bottles, moderate limits, with the long receiver hold-off
    write_all(16'd5, 16'd3, 16'd2, 16'd4, 16'd2, 16'd6, 16'd3, 8'd2);
    random_phase(32, 1'b1);

    // Extremes: single-piece bottle, zero lengths, widest gap and door limits
    write_all(16'd1, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    random_phase(32, 1'b0);

    // Opposite extremes: largest target and length limits, no gap or door limits
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 8'd0);
    random_phase(32, 1'b0);

    // Hold a piece on channel 0 well past the length limit
    write_all(16'd3, 16'd2, 16'd1, 16'd10, 16'd0, 16'd0, 16'd1, 8'd0);
    t = '{8'h00, 1'b1, RUN_GO};
    send_tick(t, 1'b0);
    t = '{8'h01, 1'b1, RUN_GO};
    for (int i = 0; i < HOLD_TICKS; i++) send_tick(t, 1'b0);
    t = '{8'h00, 1'b1, RUN_GO};
    send_tick(t, 1'b0);
    drain();

    $display("Covered %0d tick words over four register settings and four idle patterns,",
             ticks_sent);
    $display("one long output hold-off and an over-long piece; %0d status words checked.",
             words_seen);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
